// ===== hw/rtl/scca_pkg.sv =====
// ----------------------------------------------------------------------------
// scca_pkg
// Types and codes shared by the size-class chunk allocator and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package scca_pkg;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE    = 2'd1;
  localparam logic [1:0] STATUS_BAD_SIZE   = 2'd2;
  localparam logic [1:0] STATUS_BAD_OFFSET = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } scca_state_t;

  // Request item
  typedef struct packed {
    logic        mode;
    logic [9:0]  request_bytes;
    logic [10:0] free_offset;
  } scca_req_t;

  // Result item
  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] chunk_offset;
    logic [3:0]  chunk_number;
    logic [10:0] bytes_in_use;
    logic [4:0]  chunks_in_use;
  } scca_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/size_class_chunk_allocator.sv =====
// Sequence: the request is captured at the accepting edge, then S_SCAN steps
//   over the chunks one at a time and S_DONE holds the result until taken.
// A new request is taken only in S_IDLE, after the last result is taken; the
//   scan is paced by the single add/compare unit stepping over the chunk flags.
// Reset (rst, synchronous): all chunks free, usage totals zero, sequencer idle.
// ----------------------------------------------------------------------------
// size_class_chunk_allocator
// Pool of CHUNK_COUNT chunks of growing size. A sequencer walks every chunk
// once per item, claiming or releasing a chunk and recounting usage.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_chunk_allocator
  import scca_pkg::*;
#(
  parameter int CHUNK_COUNT   = 16,
  parameter int GRANULE_BYTES = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire scca_req_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output scca_rsp_t      rsp
);

  localparam int IDX_W   = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
  localparam int OFF_RAW = $clog2(GRANULE_BYTES * CHUNK_COUNT * (CHUNK_COUNT + 1) / 2 + 1);
  localparam int OFF_W   = (OFF_RAW > 11) ? OFF_RAW : 11;
  localparam int SZ_RAW  = $clog2(GRANULE_BYTES * (CHUNK_COUNT + 1) + 1);
  localparam int SZ_W    = (SZ_RAW > 10) ? SZ_RAW : 10;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHUNK_COUNT - 1);

  scca_state_t state, state_next;

  // Per-chunk busy flags and committed usage
  logic [CHUNK_COUNT-1:0] busy;
  logic [10:0]            used_bytes;
  logic [4:0]             used_chunks;

  // Captured request
  logic        mode;
  logic [9:0]  request_bytes;
  logic [10:0] free_offset;
  logic        bad_size;

  // Scan registers
  logic [IDX_W-1:0] idx;
  logic [OFF_W-1:0] start;
  logic [SZ_W-1:0]  size;
  logic             found;
  logic [10:0]      byte_acc;
  logic [4:0]       chunk_acc;
  logic [10:0]      res_off;
  logic [3:0]       res_num;

  logic        req_take, rsp_take, last_step;
  logic        claim, release_hit, busy_eff;
  logic [10:0] byte_acc_next;
  logic [4:0]  chunk_acc_next;

  assign req_take  = req_valid && !req_stall;
  assign rsp_take  = rsp_valid && !rsp_stall;
  assign last_step = (state == S_SCAN) && (idx == LAST_IDX);

  // Shared step unit: size compare / start compare, then usage accumulate
  always_comb begin
    claim       = (mode == MODE_ALLOC) && !bad_size && !found && !busy[idx] &&
                  (size >= SZ_W'(request_bytes));
    release_hit = (mode == MODE_FREE) && !found && (start == OFF_W'(free_offset));
    busy_eff    = claim || (busy[idx] && !release_hit);
    byte_acc_next  = byte_acc + (busy_eff ? 11'(size) : 11'd0);
    chunk_acc_next = chunk_acc + (busy_eff ? 5'd1 : 5'd0);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_SCAN;
      S_SCAN:  if (last_step) state_next = S_DONE;
      S_DONE:  if (rsp_take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    req_stall = (state != S_IDLE);
    rsp_valid = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state: flags and committed totals
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= '0;
      used_bytes  <= '0;
      used_chunks <= '0;
    end else if (state == S_SCAN) begin
      busy[idx] <= busy_eff;
      if (last_step) begin
        used_bytes  <= byte_acc_next;
        used_chunks <= chunk_acc_next;
      end
    end
  end

  // Capture and scan datapath
  always_ff @(posedge clk) begin
    if (req_take) begin
      mode          <= req.mode;
      request_bytes <= req.request_bytes;
      free_offset   <= req.free_offset;
      bad_size      <= (req.mode == MODE_ALLOC) && (req.request_bytes == 10'd0);
      idx           <= '0;
      start         <= '0;
      size          <= SZ_W'(GRANULE_BYTES);
      found         <= 1'b0;
      byte_acc      <= '0;
      chunk_acc     <= '0;
    end else if (state == S_SCAN) begin
      if (claim || release_hit) begin
        found   <= 1'b1;
        res_off <= 11'(start);
        res_num <= 4'(idx);
      end
      byte_acc  <= byte_acc_next;
      chunk_acc <= chunk_acc_next;
      start     <= start + OFF_W'(size);
      size      <= size + SZ_W'(GRANULE_BYTES);
      if (!last_step) idx <= idx + IDX_W'(1);
    end
  end

  // Result item
  always_comb begin
    priority if (bad_size) rsp.status = STATUS_BAD_SIZE;
    else if (found)        rsp.status = STATUS_OK;
    else if (mode == MODE_FREE) rsp.status = STATUS_BAD_OFFSET;
    else                   rsp.status = STATUS_NO_FREE;
    rsp.chunk_offset  = found ? res_off : 11'd0;
    rsp.chunk_number  = found ? res_num : 4'd0;
    rsp.bytes_in_use  = used_bytes;
    rsp.chunks_in_use = used_chunks;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scca_checker.sv =====
// ----------------------------------------------------------------------------
// scca_checker
// Port-level checks for the size-class chunk allocator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module scca_checker
  import scca_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      req_valid,
  input wire logic      req_stall,
  input wire logic      rsp_valid,
  input wire logic      rsp_stall,
  input wire scca_rsp_t rsp
);

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // Accepting a request makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall && !rsp_valid)
    else $error("block not busy after accepting a request");

  // One result per item
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall |=> !rsp_valid)
    else $error("result repeated");

  // No request taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request accepted with result pending");

  // Failed items report chunk zero at offset zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != STATUS_OK) |->
      (rsp.chunk_offset == 11'd0) && (rsp.chunk_number == 4'd0))
    else $error("failed item reports a chunk");

endmodule

bind size_class_chunk_allocator scca_checker u_scca_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

// ===== tb/tb_size_class_chunk_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_size_class_chunk_allocator
// Drives allocate and free requests into the chunk allocator and checks every
// result against a cycle-free model of the pool (busy flags plus usage totals).
// Directed corner cases come first, then random segments that push the pool
// toward full and toward empty, with random idle and stall on both channels.
// ----------------------------------------------------------------------------

module tb_size_class_chunk_allocator
  import scca_pkg::*;
;

  localparam int CHUNKS      = 16;
  localparam int GRANULE     = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 250;    // results taken before the long hold
  localparam int HOLD_LEN    = 500;    // cycles the receiver holds off
  localparam int STEADY_LO   = 600;    // no random idling on either side in this range
  localparam int STEADY_HI   = 800;

  // Queue entry: a request, or a marker that waits for the pool to go quiet
  typedef struct packed {
    logic      drain;
    scca_req_t payload;
  } queued_req_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  scca_req_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  scca_rsp_t rsp;

  queued_req_t request_queue[$];
  scca_rsp_t   predicted_results[$];

  // Model of the pool
  logic [CHUNKS-1:0] chunk_taken = '0;

  int errors         = 0;
  int accepted_count = 0;
  int received_count = 0;
  int cycle_count    = 0;

  size_class_chunk_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Byte offset of the first byte of chunk idx
  function automatic int chunk_base(input int idx);
    return GRANULE * ((idx * (idx + 1)) / 2);
  endfunction

  // Applies one request to the pool model and returns the result it gives
  function automatic scca_rsp_t allocate_or_release(input scca_req_t r);
    scca_rsp_t o;
    int        first;
    int        i;
    int        bytes;
    int        count;
    bit        found;
    o     = '0;
    found = 1'b0;
    if (r.mode == MODE_ALLOC) begin
      if (r.request_bytes == 0) begin
        o.status = STATUS_BAD_SIZE;
      end else begin
        first    = (int'(r.request_bytes) + GRANULE - 1) / GRANULE - 1;
        o.status = STATUS_NO_FREE;
        for (i = first; i < CHUNKS; i++) begin
          if (!found && !chunk_taken[i]) begin
            found          = 1'b1;
            chunk_taken[i] = 1'b1;
            o.status       = STATUS_OK;
            o.chunk_offset = 11'(chunk_base(i));
            o.chunk_number = 4'(i);
          end
        end
      end
    end else begin
      o.status = STATUS_BAD_OFFSET;
      for (i = 0; i < CHUNKS; i++) begin
        if (!found && chunk_base(i) == int'(r.free_offset)) begin
          found          = 1'b1;
          chunk_taken[i] = 1'b0;
          o.status       = STATUS_OK;
          o.chunk_offset = r.free_offset;
          o.chunk_number = 4'(i);
        end
      end
    end
    // usage totals after the item
    bytes = 0;
    count = 0;
    for (i = 0; i < CHUNKS; i++) begin
      if (chunk_taken[i]) begin
        bytes += GRANULE * (i + 1);
        count += 1;
      end
    end
    o.bytes_in_use  = 11'(bytes);
    o.chunks_in_use = 5'(count);
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", received_count, what);
    errors++;
  endtask

  // Queue fill helpers; the unused field carries random bits
  task automatic add_alloc(input int bytes);
    queued_req_t q;
    q.drain                 = 1'b0;
    q.payload.mode          = MODE_ALLOC;
    q.payload.request_bytes = 10'(bytes);
    q.payload.free_offset   = 11'($urandom);
    request_queue.push_back(q);
  endtask

  task automatic add_free(input int offset);
    queued_req_t q;
    q.drain                 = 1'b0;
    q.payload.mode          = MODE_FREE;
    q.payload.request_bytes = 10'($urandom);
    q.payload.free_offset   = 11'(offset);
    request_queue.push_back(q);
  endtask

  task automatic add_drain();
    queued_req_t q;
    q       = '0;
    q.drain = 1'b1;
    request_queue.push_back(q);
  endtask

  // Request driver
  always @(posedge clk) begin : driver
    queued_req_t head;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        predicted_results.push_back(allocate_or_release(req));
        accepted_count++;
      end
      if (!req_valid || !req_stall) begin
        if (request_queue.size() != 0 && request_queue[0].drain) begin
          // pause until every result is back
          req_valid <= 1'b0;
          if (predicted_results.size() == 0) begin
            head = request_queue.pop_front();
          end
        end else if (request_queue.size() != 0 &&
                     ((accepted_count >= STEADY_LO && accepted_count < STEADY_HI) ||
                      $urandom_range(99) >= 26)) begin
          head      = request_queue.pop_front();
          req_valid <= 1'b1;
          req       <= head.payload;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin : monitor
    scca_rsp_t want;
    int        hold_left;
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        received_count++;
        if (predicted_results.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          want = predicted_results.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("field status got %0d want %0d",
                                      rsp.status, want.status));
          if (rsp.chunk_offset !== want.chunk_offset)
            report_mismatch($sformatf("field chunk_offset got %0d want %0d",
                                      rsp.chunk_offset, want.chunk_offset));
          if (rsp.chunk_number !== want.chunk_number)
            report_mismatch($sformatf("field chunk_number got %0d want %0d",
                                      rsp.chunk_number, want.chunk_number));
          if (rsp.bytes_in_use !== want.bytes_in_use)
            report_mismatch($sformatf("field bytes_in_use got %0d want %0d",
                                      rsp.bytes_in_use, want.bytes_in_use));
          if (rsp.chunks_in_use !== want.chunks_in_use)
            report_mismatch($sformatf("field chunks_in_use got %0d want %0d",
                                      rsp.chunks_in_use, want.chunks_in_use));
        end
        if (received_count == HOLD_AT) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (received_count >= STEADY_LO && received_count < STEADY_HI) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < 26);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int seg;
    int n;
    int pct;
    int pick;

    // directed corners
    add_alloc(0);              // zero-byte request rejected
    add_alloc(1);              // smallest chunk
    add_alloc(8);              // fits chunk 0, which is taken, so moves up
    add_alloc(9);              // first size that needs chunk 1
    add_alloc(128);            // largest chunk exactly
    add_alloc(128);            // largest chunk already taken
    add_alloc(129);            // above the largest chunk
    add_alloc(1023);           // widest request
    add_free(0);               // release chunk 0
    add_free(0);               // release of a chunk that is already free
    add_free(1);               // offset inside a chunk
    add_free(chunk_base(CHUNKS - 1));
    add_free(2047);            // widest offset
    add_free(chunk_base(CHUNKS));  // one past the end of the pool
    add_free(chunk_base(1));
    add_free(chunk_base(2));
    add_alloc(64);
    add_alloc(1);
    add_alloc(0);
    add_free(chunk_base(7));

    // random segments with differing alloc shares, filling and emptying the pool
    for (seg = 0; seg < 4; seg++) begin
      add_drain();
      pct = (seg == 0) ? 75 : (seg == 1) ? 50 : (seg == 2) ? 25 : 60;
      for (n = 0; n < 385; n++) begin
        if ($urandom_range(99) < pct) begin
          pick = $urandom_range(99);
          if (pick < 7)       add_alloc(0);
          else if (pick < 15) add_alloc($urandom_range(1023, 129));
          else if (pick < 50) add_alloc($urandom_range(32, 1));
          else                add_alloc($urandom_range(128, 1));
        end else if ($urandom_range(99) < 85) begin
          add_free(chunk_base($urandom_range(CHUNKS - 1, 0)));
        end else begin
          add_free($urandom_range(2047, 0));
        end
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (request_queue.size() != 0 || req_valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/scca_pkg.sv
hw/rtl/size_class_chunk_allocator.sv
hw/rtl/scca_checker.sv
tb/tb_size_class_chunk_allocator.sv
